// File: hw/rtl/wta_pkg.sv
package wta_pkg;

  localparam int COST_W = 16;
  localparam int DISP_W = 8;
  localparam int COL_W  = 12;
  localparam int CNT_W  = 9;
  localparam int UF_W   = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 1;

  // Uniqueness scale is 1024, a left shift by this many bits.
  localparam int UNIQ_SHIFT = 10;
  localparam int LHS_W = COST_W + UNIQ_SHIFT;
  localparam int RHS_W = COST_W + UF_W;

  localparam logic [CNT_W-1:0]  DISP_COUNT_RST = 9'd64;
  localparam logic [UF_W-1:0]   UNIQ_RST       = 12'd972;
  localparam logic [CNT_W-1:0]  CNT_MAX        = 9'd256;
  localparam logic [COST_W-1:0] COST_MAX       = 16'hFFFF;
  localparam logic [DISP_W:0]   NEAR_LIMIT     = 9'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISP_COUNT = 1'b0,
    REG_UNIQUENESS = 1'b1
  } cfg_reg_t;

  // One classified cost item as it travels from the front to the back.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [DISP_W-1:0] disparity;
    logic              border;
    logic              first;
    logic              last;
    logic              within_col;
  } item_t;

  // Final pixel state handed to the decision stage.
  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic [COST_W-1:0] runner_cost;
    logic [DISP_W-1:0] min_index;
    logic [DISP_W-1:0] runner_index;
    logic [COST_W-1:0] cost_left_of_min;
    logic [COST_W-1:0] cost_right_of_min;
    logic              right_seen;
    logic              border;
  } eval_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: hw/rtl/wta_ifs.sv
interface wta_cost_if;
  logic                        valid;
  logic                        ready;
  logic [wta_pkg::COST_W-1:0]  cost;
  logic [wta_pkg::DISP_W-1:0]  disparity;
  logic [wta_pkg::COL_W-1:0]   column;

  modport source (output valid, output cost, output disparity, output column, input ready);
  modport sink   (input valid, input cost, input disparity, input column, output ready);
endinterface

interface wta_result_if;
  logic                        valid;
  logic                        ready;
  logic [wta_pkg::DISP_W-1:0]  best_disparity;
  logic                        valid_res;

  modport source (output valid, output best_disparity, output valid_res, input ready);
  modport sink   (input valid, input best_disparity, input valid_res, output ready);
endinterface

// File: hw/rtl/wta_front.sv
module wta_front (
  wta_cost_if.sink                  costs,
  input  logic [wta_pkg::CNT_W-1:0] disp_count,
  input  wta_pkg::fifo_status_t     fifo_status,
  output logic                      push,
  output wta_pkg::item_t            item
);

  logic [wta_pkg::CNT_W-1:0]  n;
  logic [wta_pkg::DISP_W-1:0] n_m1;
  logic                       ignore;

  always_comb begin
    if (disp_count == '0) begin
      n = wta_pkg::CNT_W'(1);
    end else if (disp_count > wta_pkg::CNT_MAX) begin
      n = wta_pkg::CNT_MAX;
    end else begin
      n = disp_count;
    end
  end

  assign n_m1   = wta_pkg::DISP_W'(n - wta_pkg::CNT_W'(1));
  assign ignore = {1'b0, costs.disparity} >= n;

  // Items beyond the count are dropped here and never reach the back.
  assign costs.ready = !fifo_status.full;
  assign push        = costs.valid && !fifo_status.full && !ignore;

  always_comb begin
    item.cost       = costs.cost;
    item.disparity  = costs.disparity;
    item.border     = costs.column < {{(wta_pkg::COL_W-wta_pkg::DISP_W){1'b0}}, n_m1};
    item.first      = costs.disparity == '0;
    item.last       = costs.disparity == n_m1;
    item.within_col = {{(wta_pkg::COL_W-wta_pkg::DISP_W){1'b0}}, costs.disparity}
                      <= costs.column;
  end

endmodule

// File: hw/rtl/wta_fifo.sv
module wta_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wta_pkg::item_t        push_item,
  input  logic                  pop,
  output wta_pkg::item_t        head,
  output wta_pkg::fifo_status_t status
);

  wta_pkg::item_t                  slots [wta_pkg::FIFO_DEPTH];
  logic [wta_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [wta_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [wta_pkg::FIFO_CNT_W-1:0]  count;

  assign status.full  = count == wta_pkg::FIFO_CNT_W'(wta_pkg::FIFO_DEPTH);
  assign status.empty = count == '0;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wta_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wta_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + wta_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - wta_pkg::FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/wta_back.sv
module wta_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [wta_pkg::UF_W-1:0] uniqueness_factor,
  input  wta_pkg::item_t           head,
  input  wta_pkg::fifo_status_t    fifo_status,
  output logic                     pop,
  wta_result_if.source             results
);

  logic [wta_pkg::COST_W-1:0] min_cost, min_cost_next;
  logic [wta_pkg::COST_W-1:0] runner_cost, runner_cost_next;
  logic [wta_pkg::DISP_W-1:0] min_index, min_index_next;
  logic [wta_pkg::DISP_W-1:0] runner_index, runner_index_next;
  logic [wta_pkg::COST_W-1:0] prev_cost;
  logic [wta_pkg::COST_W-1:0] cost_left_of_min, cost_left_of_min_next;
  logic [wta_pkg::COST_W-1:0] cost_right_of_min, cost_right_of_min_next;
  logic                       right_seen, right_seen_next;

  logic           ev_valid;
  wta_pkg::eval_t ev;
  logic           ev_move;

  logic                       ov;
  logic [wta_pkg::DISP_W-1:0] best_disparity;
  logic                       valid_res;

  logic                      right_hit;
  logic [wta_pkg::LHS_W-1:0] lhs;
  logic [wta_pkg::RHS_W-1:0] rhs;
  logic [wta_pkg::DISP_W:0]  diff;
  logic                      ok;

  assign ev_move = ev_valid && (!ov || results.ready);
  assign pop = !fifo_status.empty && (!head.last || !ev_valid || ev_move);

  always_comb begin
    min_cost_next          = min_cost;
    runner_cost_next       = runner_cost;
    min_index_next         = min_index;
    runner_index_next      = runner_index;
    cost_left_of_min_next  = cost_left_of_min;
    cost_right_of_min_next = cost_right_of_min;
    right_seen_next        = right_seen;
    right_hit = !right_seen &&
                ({1'b0, min_index} + 9'd1 == {1'b0, head.disparity});
    if (head.first) begin
      min_cost_next     = head.cost;
      min_index_next    = '0;
      runner_cost_next  = head.border ? head.cost : wta_pkg::COST_MAX;
      runner_index_next = '0;
      right_seen_next   = 1'b0;
    end else if (!head.border || head.within_col) begin
      if (right_hit) begin
        cost_right_of_min_next = head.cost;
        right_seen_next        = 1'b1;
      end
      // Border pixels only test the minimum when the runner-up is beaten.
      if (head.cost < min_cost && (!head.border || head.cost < runner_cost)) begin
        runner_cost_next      = min_cost;
        runner_index_next     = min_index;
        min_cost_next         = head.cost;
        min_index_next        = head.disparity;
        cost_left_of_min_next = prev_cost;
        right_seen_next       = 1'b0;
      end else if (head.cost < runner_cost) begin
        runner_cost_next  = head.cost;
        runner_index_next = head.disparity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cost          <= '0;
      runner_cost       <= '0;
      min_index         <= '0;
      runner_index      <= '0;
      prev_cost         <= '0;
      cost_left_of_min  <= '0;
      cost_right_of_min <= '0;
      right_seen        <= 1'b0;
    end else if (pop) begin
      min_cost          <= min_cost_next;
      runner_cost       <= runner_cost_next;
      min_index         <= min_index_next;
      runner_index      <= runner_index_next;
      prev_cost         <= head.cost;
      cost_left_of_min  <= cost_left_of_min_next;
      cost_right_of_min <= cost_right_of_min_next;
      right_seen        <= right_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (pop && head.last) begin
      ev_valid <= 1'b1;
    end else if (ev_move) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      ev.min_cost          <= min_cost_next;
      ev.runner_cost       <= runner_cost_next;
      ev.min_index         <= min_index_next;
      ev.runner_index      <= runner_index_next;
      ev.cost_left_of_min  <= cost_left_of_min_next;
      ev.cost_right_of_min <= cost_right_of_min_next;
      ev.right_seen        <= right_seen_next;
      ev.border            <= head.border;
    end
  end

  // Uniqueness test: 1024 * min against runner-up times the factor.
  always_comb begin
    lhs  = {ev.min_cost, {wta_pkg::UNIQ_SHIFT{1'b0}}};
    rhs  = wta_pkg::RHS_W'(ev.runner_cost) * wta_pkg::RHS_W'(uniqueness_factor);
    diff = (ev.min_index > ev.runner_index)
           ? {1'b0, ev.min_index} - {1'b0, ev.runner_index}
           : {1'b0, ev.runner_index} - {1'b0, ev.min_index};
    ok = {{(wta_pkg::RHS_W-wta_pkg::LHS_W){1'b0}}, lhs} <= rhs;
    if (!ok) begin
      if (ev.border) begin
        ok = diff < wta_pkg::NEAR_LIMIT;
      end else begin
        ok = (ev.right_seen && ev.cost_right_of_min == ev.runner_cost) ||
             (ev.min_index != '0 && ev.cost_left_of_min == ev.runner_cost);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ev_move) begin
      ov <= 1'b1;
    end else if (results.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_move) begin
      best_disparity <= ok ? ev.min_index : '0;
      valid_res      <= ok;
    end
  end

  assign results.valid          = ov;
  assign results.best_disparity = best_disparity;
  assign results.valid_res      = valid_res;

endmodule

// File: hw/rtl/wta_disparity_uniqueness_select.sv
// Channel    Role    Payload                         Transaction
// costs      sink    cost, disparity, column         one cost of one pixel disparity
// results    source  best_disparity, valid_res       one decision per pixel
// cfg_*      write   cfg_index, cfg_data             one register write per enabled edge
//
// One cost transaction is accepted every cycle while the four-entry queue has room.
// results.valid rises once the last disparity of its pixel has been accepted, then
// popped from the queue into the pixel state and snapshot, and then the result of
// the multiply and compare of the uniqueness test is registered in the output.
// Reset (rst, synchronous) empties the queue and output and restores the registers.
// A stalled result only stops the back once a further decision is pending; the
// queue then fills and costs.ready drops.
module wta_disparity_uniqueness_select (
  input  logic                           clk,
  input  logic                           rst,
  wta_cost_if.sink                       costs,
  wta_result_if.source                   results,
  input  logic                           cfg_we,
  input  logic [wta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wta_pkg::CFG_W-1:0]      cfg_data
);

  logic [wta_pkg::CNT_W-1:0] disp_count;
  logic [wta_pkg::UF_W-1:0]  uniqueness_factor;

  logic                  push;
  logic                  pop;
  wta_pkg::item_t        push_item;
  wta_pkg::item_t        head;
  wta_pkg::fifo_status_t fifo_status;

  // Config registers; user must send writes only while the block is idle, unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_count        <= wta_pkg::DISP_COUNT_RST;
      uniqueness_factor <= wta_pkg::UNIQ_RST;
    end else if (cfg_we) begin
      unique case (wta_pkg::cfg_reg_t'(cfg_index))
        wta_pkg::REG_DISP_COUNT: disp_count        <= cfg_data[wta_pkg::CNT_W-1:0];
        wta_pkg::REG_UNIQUENESS: uniqueness_factor <= cfg_data[wta_pkg::UF_W-1:0];
        default: ;
      endcase
    end
  end

  // The front clamps the count, tags each cost as first, last, border and within
  // the column, and drops costs past the count.
  wta_front u_front (
    .costs       (costs),
    .disp_count  (disp_count),
    .fifo_status (fifo_status),
    .push        (push),
    .item        (push_item)
  );

  wta_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (fifo_status)
  );

  // The back tracks the minimum, runner-up and neighbor costs, and on the last
  // disparity hands a snapshot to the uniqueness test and the output register.
  wta_back u_back (
    .clk               (clk),
    .rst               (rst),
    .uniqueness_factor (uniqueness_factor),
    .head              (head),
    .fifo_status       (fifo_status),
    .pop               (pop),
    .results           (results)
  );

endmodule

// File: test/tb_wta_disparity_uniqueness_select.sv
module tb_wta_disparity_uniqueness_select;
  import wta_pkg::*;

  // Cycles to let pass after the last expected decision before a register
  // write or the end of the run. The block holds up to four costs in its
  // queue before it pops them into its pixel state and decides, so this covers
  // costs that are still inside it but cause no decision.
  localparam int SETTLE_CYCLES = 16;

  // Length of the deliberate stall on the decision channel. It is far longer
  // than the time needed to fill the queue, so the cost channel must stall.
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  wta_cost_if   cost_ch ();
  wta_result_if decision_ch ();

  // Set by the stimulus to stop random idling on both channels, and to ask
  // the receiver for one long stall.
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  wta_disparity_uniqueness_select dut (
    .clk       (clk),
    .rst       (rst),
    .costs     (cost_ch),
    .results   (decision_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One expected decision: the winning disparity and whether it was accepted.
  typedef struct {
    logic [DISP_W-1:0] best_disparity;
    logic              accepted;
  } decision_t;

  // The scoreboard tracks the per-pixel search the way the block should:
  // a running minimum and runner-up, the costs on either side of the
  // minimum, and the register settings in force. Every accepted cost
  // transaction goes through note_cost; the last disparity of a pixel
  // queues the decision that the block must produce.
  class disparity_scoreboard;
    int unsigned disp_count_reg;
    int unsigned uniq_factor_reg;
    logic [COST_W-1:0] min_cost;
    logic [COST_W-1:0] runner_cost;
    logic [COST_W-1:0] prev_cost;
    logic [COST_W-1:0] cost_left;
    logic [COST_W-1:0] cost_right;
    logic [DISP_W-1:0] min_index;
    logic [DISP_W-1:0] runner_index;
    bit right_seen;
    decision_t pending[$];
    int failures;
    int border_pixels;
    int interior_pixels;
    int rescued;
    int rejected;
    int ignored;

    function new();
      disp_count_reg  = 32'(DISP_COUNT_RST);
      uniq_factor_reg = 32'(UNIQ_RST);
      min_cost     = '0;
      runner_cost  = '0;
      prev_cost    = '0;
      cost_left    = '0;
      cost_right   = '0;
      min_index    = '0;
      runner_index = '0;
      right_seen   = 1'b0;
    endfunction

    function void write_register(cfg_reg_t idx, int unsigned value);
      if (idx == REG_DISP_COUNT) begin
        disp_count_reg = value & 32'h1FF;
      end else begin
        uniq_factor_reg = value & 32'hFFF;
      end
    endfunction

    function void note_cost(logic [COST_W-1:0] c, logic [DISP_W-1:0] d,
                            logic [COL_W-1:0] col);
      int unsigned n;
      int gap;
      bit border;
      bit ok;
      longint unsigned lhs;
      longint unsigned rhs;
      decision_t dec;
      n = disp_count_reg;
      if (n < 1) n = 1;
      if (n > CNT_MAX) n = 32'(CNT_MAX);
      border = col < n - 1;
      if (d >= n) begin
        ignored++;
        return;
      end
      if (d == 0) begin
        min_cost     = c;
        min_index    = '0;
        runner_cost  = border ? c : COST_MAX;
        runner_index = '0;
        right_seen   = 1'b0;
      end else if (!border || d <= col) begin
        if (!right_seen && int'(min_index) + 1 == int'(d)) begin
          cost_right = c;
          right_seen = 1'b1;
        end
        // The minimum never exceeds the runner-up, so a new minimum is
        // always below the runner-up as well.
        if (c < min_cost) begin
          runner_cost  = min_cost;
          runner_index = min_index;
          min_cost     = c;
          min_index    = d;
          cost_left    = prev_cost;
          right_seen   = 1'b0;
        end else if (c < runner_cost) begin
          runner_cost  = c;
          runner_index = d;
        end
      end
      prev_cost = c;
      if (d != n - 1) return;

      lhs = 64'(min_cost);
      lhs = lhs << UNIQ_SHIFT;
      rhs = 64'(runner_cost);
      rhs = rhs * 64'(uniq_factor_reg);
      ok = lhs <= rhs;
      if (!ok) begin
        if (border) begin
          gap = int'(min_index) - int'(runner_index);
          ok = gap < 2 && gap > -2;
        end else begin
          ok = (right_seen && cost_right == runner_cost) ||
               (min_index != 0 && cost_left == runner_cost);
        end
        if (ok) rescued++;
      end
      if (border) border_pixels++;
      else interior_pixels++;
      if (!ok) rejected++;
      dec.best_disparity = ok ? min_index : '0;
      dec.accepted = ok;
      pending.push_back(dec);
    endfunction

    function void check_decision(logic [DISP_W-1:0] best, logic flag);
      decision_t want;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: unexpected decision: best_disparity %0d valid_res %b",
                 $time, best, flag);
        return;
      end
      want = pending.pop_front();
      if (best !== want.best_disparity) begin
        failures++;
        $display("%0t: best_disparity expected %0d, got %0d",
                 $time, want.best_disparity, best);
      end
      if (flag !== want.accepted) begin
        failures++;
        $display("%0t: valid_res expected %b, got %b", $time, want.accepted, flag);
      end
    endfunction
  endclass

  disparity_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; a correct run finishes well before this.
  initial begin
    #3000000;
    $display("** wta_disparity_uniqueness_select: FAILED **");
    $finish;
  end

  // Decision receiver. Every transaction is checked against the oldest
  // expectation. Ready drops in about one cycle of eight, never while the
  // stimulus asks for a steady stretch, and for a long run of cycles once
  // when the stimulus asks for a stall.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    decision_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && decision_ch.valid && decision_ch.ready) begin
        sb.check_decision(decision_ch.best_disparity, decision_ch.valid_res);
      end
      if (hold_left > 0) begin
        hold_left--;
        decision_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        decision_ch.ready <= 1'b0;
      end else begin
        decision_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Register count as the block uses it.
  function automatic int unsigned used_count(int unsigned count_reg);
    int unsigned n;
    n = count_reg & 32'h1FF;
    if (n < 1) n = 1;
    if (n > CNT_MAX) n = 32'(CNT_MAX);
    return n;
  endfunction

  // Columns lean toward the border region and its edge at count-1, where
  // the block switches between the two uniqueness rules.
  function automatic int unsigned pick_column(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (n >= 2 && r < 45) return $urandom_range(0, n - 2);
    if (r < 55) return n - 1;
    if (r < 60) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  // Cost shapes: fully random, tiny values full of ties, values close to a
  // base so that the ratio test is near its threshold, and the two extremes.
  function automatic logic [COST_W-1:0] pick_cost(int style, int unsigned base);
    int unsigned v;
    case (style)
      1: begin
        v = $urandom_range(0, 7);
      end
      2: begin
        v = base + $urandom_range(0, base >> 4);
        if (v > COST_MAX) v = 32'(COST_MAX);
      end
      3: begin
        v = $urandom_range(0, 1) ? 32'(COST_MAX) : 32'd0;
      end
      default: begin
        v = $urandom_range(0, 65535);
      end
    endcase
    return v[COST_W-1:0];
  endfunction

  // Both registers are written on back-to-back enabled edges.
  task automatic configure(int unsigned count_reg, int unsigned uf_reg);
    cfg_we <= 1'b1;
    cfg_index <= REG_DISP_COUNT;
    cfg_data <= CFG_W'(count_reg);
    @(posedge clk);
    sb.write_register(REG_DISP_COUNT, count_reg);
    cfg_index <= REG_UNIQUENESS;
    cfg_data <= CFG_W'(uf_reg);
    @(posedge clk);
    sb.write_register(REG_UNIQUENESS, uf_reg);
    cfg_we <= 1'b0;
  endtask

  // Offers one cost transaction and returns at the edge that accepts it.
  // Valid stays high afterwards so back-to-back transactions need no gap.
  task automatic send_cost(logic [COST_W-1:0] c, logic [DISP_W-1:0] d,
                           logic [COL_W-1:0] col);
    if (!steady && $urandom_range(0, 99) < 9) begin
      cost_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    cost_ch.valid <= 1'b1;
    cost_ch.cost <= c;
    cost_ch.disparity <= d;
    cost_ch.column <= col;
    @(posedge clk);
    while (!cost_ch.ready) @(posedge clk);
    sb.note_cost(c, d, col);
  endtask

  // Waits until every expected decision has arrived, then lets the block
  // finish any costs that are still inside it.
  task automatic settle();
    cost_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hand-picked pixels at a count of three: extreme costs, a border pixel
  // whose later costs lie past its column, both neighbour rescues, the
  // near-index rule, a plain rejection, an out-of-range disparity and a
  // pixel whose column changes between border and interior.
  task automatic directed_pixels();
    configure(3, 972);
    send_cost(16'd0, 8'd0, 12'd4095);
    send_cost(COST_MAX, 8'd1, 12'd4095);
    send_cost(COST_MAX, 8'd2, 12'd4095);
    send_cost(16'd5, 8'd0, 12'd0);
    send_cost(16'd3, 8'd1, 12'd0);
    send_cost(16'd1, 8'd2, 12'd0);
    send_cost(16'd1010, 8'd0, 12'd2);
    send_cost(16'd1000, 8'd1, 12'd2);
    send_cost(16'd2000, 8'd2, 12'd2);
    send_cost(16'd1000, 8'd0, 12'd2);
    send_cost(16'd1000, 8'd1, 12'd2);
    send_cost(16'd3000, 8'd2, 12'd2);
    send_cost(16'hABCD, 8'd255, 12'd4095);
    send_cost(16'd1010, 8'd0, 12'd1);
    send_cost(16'd1000, 8'd1, 12'd1);
    send_cost(16'd7, 8'd2, 12'd1);
    send_cost(16'd100, 8'd0, 12'd9);
    send_cost(16'd300, 8'd1, 12'd9);
    send_cost(16'd101, 8'd2, 12'd9);
    send_cost(16'd50, 8'd0, 12'd0);
    send_cost(16'd20, 8'd1, 12'd4095);
    send_cost(16'd60, 8'd2, 12'd1);
    settle();
  endtask

  // One register setting and a stream of pixels under it. Most pixels are
  // complete and in order, with an occasional stray out-of-range cost or a
  // column that changes for one cost. The rest are abandoned pixels,
  // scrambled disparities and pure out-of-range noise. The budget counts
  // only costs the block acts on.
  task automatic run_phase(int unsigned count_reg, int unsigned uf_reg, int budget);
    int unsigned n;
    int unsigned col;
    int unsigned base;
    int sent;
    int kind;
    int style;
    int stop;
    configure(count_reg, uf_reg);
    n = used_count(count_reg);
    sent = 0;
    while (sent < budget) begin
      kind  = $urandom_range(0, 99);
      col   = pick_column(n);
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 60000);
      if (kind < 80) begin
        for (int d = 0; d < n; d++) begin
          if (n < 256 && $urandom_range(0, 99) < 3) begin
            send_cost(pick_cost(0, 0), DISP_W'($urandom_range(n, 255)),
                      COL_W'($urandom_range(0, 4095)));
          end
          send_cost(pick_cost(style, base), DISP_W'(d),
                    COL_W'(($urandom_range(0, 99) < 3) ? pick_column(n) : col));
          sent++;
        end
      end else if (kind < 90) begin
        stop = $urandom_range(0, n - 1);
        for (int d = 0; d <= stop; d++) begin
          send_cost(pick_cost(style, base), DISP_W'(d), COL_W'(col));
          sent++;
        end
      end else if (kind < 96) begin
        repeat ($urandom_range(1, (n < 8) ? n : 8)) begin
          send_cost(pick_cost(style, base), DISP_W'($urandom_range(0, n - 1)),
                    COL_W'(col));
          sent++;
        end
      end else if (n < 256) begin
        send_cost(pick_cost(0, 0), DISP_W'($urandom_range(n, 255)),
                  COL_W'($urandom_range(0, 4095)));
      end
    end
    settle();
  endtask

  initial begin : stimulus
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DISP_COUNT;
    cfg_data <= '0;
    cost_ch.valid <= 1'b0;
    cost_ch.cost <= '0;
    cost_ch.disparity <= '0;
    cost_ch.column <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_pixels();

    // Two disparities per pixel finish a decision every other cost, so the
    // long receiver stall here fills the queue and backs up the costs.
    // Neither side idles during this phase.
    steady = 1'b1;
    hold_request = 1'b1;
    run_phase(2, 1024, 260);
    steady = 1'b0;

    run_phase(8, 0, 200);
    run_phase(1, 2048, 60);
    run_phase(256, 972, 256);
    run_phase(5, 4095, 200);
    run_phase(16, $urandom_range(900, 1100), 260);
    run_phase(0, 1, 40);
    run_phase(300, 1023, 256);
    run_phase(64, 972, 350);

    $display("Covered %0d pixel decisions (%0d border, %0d interior), %0d rescued, %0d rejected,",
             sb.border_pixels + sb.interior_pixels, sb.border_pixels,
             sb.interior_pixels, sb.rescued, sb.rejected);
    $display("over ten register settings with %0d out-of-range costs ignored.",
             sb.ignored);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("** wta_disparity_uniqueness_select: PASSED **");
    end else begin
      $display("** wta_disparity_uniqueness_select: FAILED **");
    end
    $finish;
  end

endmodule
